// ===== hw/rtl/bce_pkg.sv =====
// shared types and constants for the battery charge estimator
package bce_pkg;

    localparam int PIN_W       = 12;
    localparam int RATIO_W     = 12;
    localparam int MV_W        = 16;
    localparam int PCT_W       = 7;
    localparam int PROD_W      = MV_W + RATIO_W;
    localparam int Q8_SHIFT    = 8;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    // shared multiplier, sized for the scaled voltage times the group reciprocal
    localparam int SCALED_W    = PROD_W - Q8_SHIFT;
    localparam int MUL_A_W     = SCALED_W;
    localparam int MUL_B_W     = 21;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    // segment interpolation: 10x offset times ceil(2^SEG_SH / span), quotient below 10
    localparam int SEG_SH      = 19;
    localparam int RECIP_W     = 14;
    localparam int FRAC_W      = 4;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 12'd512;

    localparam logic [MV_W-1:0] MV_MAX   = 16'hFFFF;
    localparam logic [MV_W-1:0] MV_CONN  = 16'd2800;
    localparam logic [MV_W-1:0] MV_FULL  = 16'd4180;
    localparam logic [MV_W-1:0] MV_EMPTY = 16'd3250;

    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    // discharge curve, highest segment first
    localparam int NSEG  = 10;
    localparam int SEG_W = $clog2(NSEG);
    localparam logic [MV_W-1:0] SEG_LO [NSEG] = '{
        16'd4050, 16'd3950, 16'd3860, 16'd3800, 16'd3750,
        16'd3700, 16'd3650, 16'd3600, 16'd3450, 16'd3250
    };
    // spans 130, 100, 90, 60, 50, 50, 50, 50, 150, 200
    localparam logic [RECIP_W-1:0] SEG_RECIP [NSEG] = '{
        14'd4033, 14'd5243, 14'd5826, 14'd8739, 14'd10486,
        14'd10486, 14'd10486, 14'd10486, 14'd3496, 14'd2622
    };
    localparam logic [PCT_W-1:0] SEG_BASE [NSEG] = '{
        7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd10, 7'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV1,
        ST_SEG,
        ST_DIV2,
        ST_FIN
    } state_t;

endpackage

// ===== hw/rtl/bce_div.sv =====
// shared multiplier; the constant divisions run through it as reciprocal products
module bce_div (
    input  logic [bce_pkg::MUL_A_W-1:0] mul_a,
    input  logic [bce_pkg::MUL_B_W-1:0] mul_b,
    output logic [bce_pkg::MUL_P_W-1:0] mul_p
);
    import bce_pkg::*;

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

endmodule

// ===== hw/rtl/battery_charge_estimator.sv =====
// battery voltage averaging and lipo state-of-charge estimation, top level
// samples are taken in ST_IDLE while a group fills; a closing sample's transfer starts the
//   sequencer through ST_MUL, ST_DIV1, ST_SEG, ST_DIV2 (skipped outside the curve) and
//   ST_FIN, with ST_MUL, ST_DIV1 and ST_DIV2 each using the shared multiplier; s_tready
//   stays low until ST_FIN loads the output register, and ST_FIN holds while it waits on m_tready
// reset: async active low; clears sum, count, sequencer, output valid; ratio returns to 512
module battery_charge_estimator #(
    parameter int SAMPLES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bce_pkg::RATIO_W-1:0]         cfg_data,    // divider_ratio_q8
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bce_pkg::IN_DATA_W-1:0]       s_tdata,     // [11:0] pin_mv
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bce_pkg::OUT_DATA_W-1:0]      m_tdata      // [15:0] battery_mv,
                                                             // [16] connected,
                                                             // [23:17] percent
);
    import bce_pkg::*;

    localparam int CNT_W    = $clog2(SAMPLES + 1);
    // floor(x / SAMPLES) as (x * RECIP_S) >> RECIP_SH, exact for any 20-bit x
    localparam int RECIP_SH = SCALED_W + $clog2(SAMPLES);
    localparam longint RECIP_S = ((longint'(1) << RECIP_SH) + longint'(SAMPLES) - 1) /
                                 longint'(SAMPLES);

    state_t state_reg, state_next;

    logic [RATIO_W-1:0]    ratio_reg, ratio_next;
    logic [MV_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [MV_W-1:0]       work_reg, work_next;
    logic [SCALED_W-1:0]   scaled_reg, scaled_next;
    logic [MV_W-1:0]       mv_reg, mv_next;
    logic [SEG_W-1:0]      seg_reg, seg_next;
    logic [PCT_W-1:0]      pct_reg, pct_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  in_xfer;
    logic                  group_end;
    logic [MV_W-1:0]       sum_add;
    logic [CNT_W-1:0]      cnt_inc;
    logic [SCALED_W-1:0]   scaled_q;
    logic [MV_W-1:0]       mv_sat;
    logic                  conn;
    logic                  seg_run;
    logic [SEG_W-1:0]      seg_idx;
    logic [MV_W-1:0]       seg_off;
    logic [MV_W-1:0]       seg_num;
    logic                  out_load;

    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]    mul_p;

    bce_div u_mul (
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign sum_add   = sum_reg + MV_W'(s_tdata[PIN_W-1:0]);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign group_end = cnt_inc == CNT_W'(SAMPLES);

    assign scaled_q = SCALED_W'(mul_p >> RECIP_SH);
    assign mv_sat   = (|scaled_q[SCALED_W-1:MV_W]) ? MV_MAX : scaled_q[MV_W-1:0];
    assign conn     = mv_reg > MV_CONN;
    // strictly inside the curve; anything not connected lies below the empty point
    assign seg_run  = (mv_reg > MV_EMPTY) && (mv_reg < MV_FULL);

    always_comb
    begin
        seg_idx = '0;
        for (int i = NSEG - 1; i >= 0; i--)
        begin
            if (mv_reg >= SEG_LO[i])
                seg_idx = SEG_W'(i);
        end
    end

    // offset into a segment stays below 200, so 10x fits easily
    assign seg_off = mv_reg - SEG_LO[seg_idx];
    assign seg_num = (seg_off << 3) + (seg_off << 1);

    // shared multiplier operands per step
    always_comb
    begin
        case (state_reg)
            ST_MUL:
            begin
                mul_a = MUL_A_W'(work_reg);
                mul_b = MUL_B_W'(ratio_reg);
            end
            ST_DIV1:
            begin
                mul_a = scaled_reg;
                mul_b = MUL_B_W'(RECIP_S);
            end
            ST_DIV2:
            begin
                mul_a = MUL_A_W'(work_reg);
                mul_b = MUL_B_W'(SEG_RECIP[seg_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && group_end)
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_DIV1;
            ST_DIV1:
                state_next = ST_SEG;
            ST_SEG:
                state_next = seg_run ? ST_DIV2 : ST_FIN;
            ST_DIV2:
                state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
                s_tready = 1'b1;
            ST_FIN:
                out_load = !out_valid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        ratio_next     = ratio_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        work_next      = work_reg;
        scaled_next    = scaled_reg;
        mv_next        = mv_reg;
        seg_next       = seg_reg;
        pct_next       = pct_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready)
            ratio_next = cfg_data;

        if (in_xfer)
        begin
            if (group_end)
            begin
                work_next = sum_add;
                sum_next  = '0;
                cnt_next  = '0;
            end
            else
            begin
                sum_next = sum_add;
                cnt_next = cnt_inc;
            end
        end

        if (state_reg == ST_MUL)
            scaled_next = mul_p[PROD_W-1:Q8_SHIFT];

        if (state_reg == ST_DIV1)
            mv_next = mv_sat;

        if (state_reg == ST_SEG)
        begin
            work_next = seg_num;
            seg_next  = seg_idx;
            pct_next  = (mv_reg >= MV_FULL) ? PCT_FULL : PCT_EMPTY;
        end

        if (state_reg == ST_DIV2)
            pct_next = SEG_BASE[seg_reg] + PCT_W'(mul_p[SEG_SH +: FRAC_W]);

        if (m_tvalid && m_tready)
            out_valid_next = 1'b0;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {pct_reg, conn, mv_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ratio_reg     <= RATIO_RESET;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ratio_reg     <= ratio_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        scaled_reg   <= scaled_next;
        mv_reg       <= mv_next;
        seg_reg      <= seg_next;
        pct_reg      <= pct_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(SAMPLES))
        else $error("sample count reached group size");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV2) |-> (mul_p[MUL_P_W-1:SEG_SH+FRAC_W] == '0))
        else $error("interpolation step beyond one segment");

    a_conn_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16] == (m_tdata[15:0] > MV_CONN)))
        else $error("connected flag disagrees with voltage");

    a_pct_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[23:17] == PCT_EMPTY))
        else $error("charge reported while disconnected");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:17] <= PCT_FULL))
        else $error("charge above full");
`endif

endmodule

// ===== sim/bce_checker.sv =====
// checker for the battery charge estimator: predicts each group result and compares
`timescale 1ns / 100ps

module bce_checker #(
    parameter int GROUP_LEN = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [bce_pkg::RATIO_W-1:0]      cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [bce_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [bce_pkg::OUT_DATA_W-1:0]   m_tdata,
    output int                               mismatch_count,
    output int                               results_due
);
    import bce_pkg::*;

    // laid out to match m_tdata, battery_mv in the low bits
    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic             connected;
        logic [MV_W-1:0]  battery_mv;
    } soc_result_t;

    localparam int unsigned CURVE_LO [10] = '{4050, 3950, 3860, 3800, 3750,
                                              3700, 3650, 3600, 3450, 3250};
    localparam int unsigned CURVE_HI [10] = '{4180, 4050, 3950, 3860, 3800,
                                              3750, 3700, 3650, 3600, 3450};

    logic [RATIO_W-1:0] ratio_q8;
    logic [MV_W-1:0]    pin_sum;
    int                 pin_count;
    soc_result_t        soc_expected [$];

    function automatic logic [PCT_W-1:0] charge_of(input int unsigned mv);
        int unsigned pct;
        bit          hit;
        int          i;
        pct = 0;
        hit = 1'b0;
        if (mv >= 4180)
        begin
            pct = 100;
        end
        else if (mv > 3250)
        begin
            // segments run from the top of the curve down
            for (i = 0; i < 10; i++)
            begin
                if (!hit && mv >= CURVE_LO[i])
                begin
                    pct = 90 - 10 * i + (10 * (mv - CURVE_LO[i])) / (CURVE_HI[i] - CURVE_LO[i]);
                    hit = 1'b1;
                end
            end
        end
        return pct[PCT_W-1:0];
    endfunction

    function automatic soc_result_t predict_soc(input logic [MV_W-1:0] sum,
                                                input logic [RATIO_W-1:0] ratio);
        longint unsigned scaled;
        soc_result_t     r;
        scaled = sum;
        scaled = (scaled * ratio) / (256 * GROUP_LEN);
        r.battery_mv = (scaled > 65535) ? 16'hFFFF : scaled[MV_W-1:0];
        r.connected  = (r.battery_mv > 16'd2800);
        r.percent    = r.connected ? charge_of(r.battery_mv) : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [MV_W-1:0] next_sum;
        soc_result_t     got;
        soc_result_t     want;
        int              delta;
        int              errs;
        if (!rst_n)
        begin
            ratio_q8       = RATIO_RESET;
            pin_sum        = '0;
            pin_count      = 0;
            mismatch_count <= 0;
            results_due    <= 0;
        end
        else
        begin
            delta = 0;
            errs  = 0;
            if (cfg_valid && cfg_ready)
                ratio_q8 = cfg_data;
            if (s_tvalid && s_tready)
            begin
                next_sum = pin_sum + s_tdata[PIN_W-1:0];
                if (pin_count + 1 == GROUP_LEN)
                begin
                    soc_expected.push_back(predict_soc(next_sum, ratio_q8));
                    pin_sum   = '0;
                    pin_count = 0;
                    delta++;
                end
                else
                begin
                    pin_sum = next_sum;
                    pin_count++;
                end
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (soc_expected.size() == 0)
                begin
                    $error("result with nothing expected: battery_mv %0d", got.battery_mv);
                    errs++;
                end
                else
                begin
                    want = soc_expected.pop_front();
                    delta--;
                    if (got.battery_mv !== want.battery_mv)
                    begin
                        $error("battery_mv: expected %0d, got %0d",
                               want.battery_mv, got.battery_mv);
                        errs++;
                    end
                    if (got.connected !== want.connected)
                    begin
                        $error("connected: expected %0d, got %0d",
                               want.connected, got.connected);
                        errs++;
                    end
                    if (got.percent !== want.percent)
                    begin
                        $error("percent: expected %0d, got %0d", want.percent, got.percent);
                        errs++;
                    end
                end
            end
            mismatch_count <= mismatch_count + errs;
            results_due    <= results_due + delta;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// top of the battery charge estimator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;

    import bce_pkg::*;

    localparam int GROUP_LEN   = 16;
    localparam int SETTLE      = 60;
    localparam int QUIET_LIMIT = 5000;
    localparam int KNEE_MV [12] = '{2800, 3250, 3450, 3600, 3650, 3700,
                                    3750, 3800, 3860, 3950, 4050, 4180};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [RATIO_W-1:0]    cfg_data;     // divider_ratio_q8
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;      // [11:0] pin_mv
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;      // [15:0] battery_mv, [16] connected, [23:17] percent

    int                    mismatch_count;
    int                    results_due;
    int                    quiet_cycles = 0;
    int                    group_pos;
    int                    ratio_now;
    bit                    tx_steady;
    bit                    rx_steady;

    battery_charge_estimator #(
        .SAMPLES (GROUP_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bce_checker #(
        .GROUP_LEN (GROUP_LEN)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // any transfer on any channel keeps the run alive
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("battery_charge_estimator verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: unless rx_steady, stall a random number of cycles after each transfer
    initial
    begin : drain
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                stall = rx_steady ? 0 : $urandom_range(0, 5);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_pin(input int pin_mv);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(pin_mv[PIN_W-1:0]);
        do
            @(posedge clk);
        while (!s_tready);
        group_pos = (group_pos + 1) % GROUP_LEN;
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_pin($urandom_range(0, 4095));
    endtask

    // fill the rest of the current group with pins that average near target_mv (any level while the ratio is 0)
    task automatic send_near(input int target_mv);
        int base;
        int jit;
        int pin;
        int n;
        n = GROUP_LEN - group_pos;
        if (ratio_now == 0)
            base = $urandom_range(0, 4095);
        else
            base = (target_mv * 256 + ratio_now / 2) / ratio_now;
        if (base > 4095)
            base = 4095;
        jit = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        repeat (n)
        begin
            pin = base + int'($urandom_range(0, 2 * jit)) - jit;
            if (pin < 0)
                pin = 0;
            if (pin > 4095)
                pin = 4095;
            send_pin(pin);
        end
    endtask

    task automatic settle_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_ratio(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= RATIO_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ratio_now = value;
    endtask

    initial
    begin : stimulus
        int phase;
        int g;
        int kind;
        int ratio;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        group_pos = 0;
        ratio_now = RATIO_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset ratio, pins at both ends of their range in one group
        tx_steady = 1'b1;
        repeat (8) send_pin(0);
        repeat (8) send_pin(4095);

        for (phase = 0; phase < 10; phase++)
        begin
            settle_idle();
            case (phase)
                0:       ratio = 256;
                1:       ratio = 4095;
                2:       ratio = 0;
                3:       ratio = 255;
                4:       ratio = 512;
                default: ratio = (phase % 2) ? $urandom_range(256, 4095) : $urandom_range(0, 4095);
            endcase
            write_ratio(ratio);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (g = 0; g < 10; g++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 2)
                    send_noise(GROUP_LEN - group_pos);
                else if (kind < 6)
                    send_near(KNEE_MV[$urandom_range(0, 11)] + int'($urandom_range(0, 4)) - 2);
                else
                    send_near($urandom_range(2600, 4400));
            end
            // sometimes leave a group partly filled across the ratio change
            if ($urandom_range(0, 2) == 0)
                send_noise($urandom_range(1, GROUP_LEN - 1));
        end

        settle_idle();
        if (mismatch_count == 0)
            $display("battery_charge_estimator verification clean");
        else
            $display("battery_charge_estimator verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bce_pkg.sv
hw/rtl/bce_div.sv
hw/rtl/battery_charge_estimator.sv
sim/bce_checker.sv
sim/testbench.sv
